// ===== design/aptr_pkg.sv =====
package aptr_pkg;

  // Instruction decode constants
  localparam logic [31:0] ADRP_MASK  = 32'h9F00_0000;
  localparam logic [31:0] ADRP_OP    = 32'h9000_0000;
  localparam logic [31:0] KEEP_MASK  = 32'h9F00_001F;

  localparam int IMM_W      = 21;
  localparam int PAGE_SHIFT = 12;
  localparam int REG_W      = 48;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_BASE     = 3'd0,
    REG_PHANTOM_START = 3'd1,
    REG_PHANTOM_END   = 3'd2,
    REG_DATA_BASE     = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic patched;
    logic skipped;
  } aptr_flags_t;

endpackage

// ===== design/adrp_page_target_rewriter.sv =====
// Channel | Handshake             | Payload
// --------+-----------------------+-------------------------------------------
// in      | in_valid / in_stall   | instr_word, word_offset
// out     | out_valid / out_stall | out_word, was_patched, was_skipped
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready tied high)
//
// Throughput: one item per cycle while out is not stalled; five register stages,
// the last being the output register that drives out_valid.
// Pipeline: decode + pc add, target add, window compare, distance add, encode.
// A stall on out freezes every stage at once; in_stall follows it the same cycle.
// Bubbles are carried by per-stage valid bits and never emitted.
// Reset (rst, synchronous) clears valids and the four address registers.
module adrp_page_target_rewriter import aptr_pkg::*; #(
  parameter int OFFSET_BITS = 28,
  parameter int ADDR_BITS   = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  // item input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            instr_word,
  input  logic [OFFSET_BITS-1:0] word_offset,
  // item output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_word,
  output logic                   was_patched,
  output logic                   was_skipped,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  // pc width covers code_base plus the scaled offset with one carry bit
  localparam int PCW = ((OFFSET_BITS + 2) > REG_W ? (OFFSET_BITS + 2) : REG_W) + 1;
  localparam int TW  = PCW + 1;  // target width
  localparam int ST  = TW + 1;   // signed target sum
  localparam int DW  = PCW + 1;  // data_base - page, signed
  localparam int XW  = TW + 2;   // byte distance, signed

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0] code_base;
  logic [REG_W-1:0] phantom_start;
  logic [REG_W-1:0] phantom_end;
  logic [REG_W-1:0] data_base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_base     <= '0;
      phantom_start <= '0;
      phantom_end   <= '0;
      data_base     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CODE_BASE:     code_base     <= cfg_data;
        REG_PHANTOM_START: phantom_start <= cfg_data;
        REG_PHANTOM_END:   phantom_end   <= cfg_data;
        REG_DATA_BASE:     data_base     <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance: every stage holds while the output item is stalled
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv      = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  // Stage 1: decode ADRP, form the word's own pc
  logic                    v1;
  logic [31:0]             word1;
  logic                    adrp1;
  logic signed [IMM_W-1:0] imm1;
  logic [PCW-1:0]          pc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word1 <= instr_word;
      adrp1 <= (instr_word & ADRP_MASK) == ADRP_OP;
      imm1  <= {instr_word[23:5], instr_word[30:29]};
      pc1   <= PCW'(code_base) + PCW'({word_offset, 2'b00});
    end
  end

  // Stage 2: target page, range checks, data_base relative to own page
  logic [PCW-1:0]       page1;
  logic signed [ST-1:0] tsum1;
  logic                 over1;

  logic                 v2;
  logic [31:0]          word2;
  logic                 hit2;
  logic [TW-1:0]        tgt2;
  logic signed [DW-1:0] brel2;

  always_comb begin
    page1 = {pc1[PCW-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    tsum1 = $signed({2'b00, page1}) + (ST'(imm1) <<< PAGE_SHIFT);
    // upward targets beyond the address space never match
    over1 = ~imm1[IMM_W-1] & (|(tsum1[TW-1:0] >> ADDR_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word2 <= word1;
      hit2  <= adrp1 & ~tsum1[ST-1] & ~over1;
      tgt2  <= tsum1[TW-1:0];
      brel2 <= $signed(DW'(data_base)) - $signed({1'b0, page1});
    end
  end

  // Stage 3: window compare, offset into the window
  logic                 v3;
  logic [31:0]          word3;
  logic                 match3;
  logic [TW-1:0]        woff3;
  logic signed [DW-1:0] brel3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word3  <= word2;
      match3 <= hit2 & (tgt2 >= TW'(phantom_start)) & (tgt2 < TW'(phantom_end));
      woff3  <= tgt2 - TW'(phantom_start);
      brel3  <= brel2;
    end
  end

  // Stage 4: byte distance from own page to the new target
  logic                 v4;
  logic [31:0]          word4;
  logic                 match4;
  logic signed [XW-1:0] dist4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word4  <= word3;
      match4 <= match3;
      dist4  <= $signed({2'b00, woff3}) + XW'(brel3);
    end
  end

  // Stage 5: page quotient, reach check, re-encode into the output register
  logic [31:0] enc_word;
  aptr_flags_t enc_flags;

  aptr_encode #(
    .DW (XW)
  ) u_encode (
    .byte_dist (dist4),
    .word      (word4),
    .match     (match4),
    .word_out  (enc_word),
    .flags     (enc_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word    <= enc_word;
      was_patched <= enc_flags.patched;
      was_skipped <= enc_flags.skipped;
    end
  end

endmodule

// ===== design/aptr_encode.sv =====
module aptr_encode import aptr_pkg::*; #(
  parameter int DW = 53
) (
  input  logic signed [DW-1:0] byte_dist,
  input  logic [31:0]          word,
  input  logic                 match,
  output logic [31:0]          word_out,
  output aptr_flags_t          flags
);

  localparam int QW = DW - PAGE_SHIFT;

  logic              adj;
  logic signed [QW-1:0] q;
  logic              fits;
  logic [31:0]       enc;

  always_comb begin
    // Round the page distance toward zero: bump the floor when negative and inexact
    adj  = byte_dist[DW-1] & (|byte_dist[PAGE_SHIFT-1:0]);
    q    = byte_dist[DW-1:PAGE_SHIFT] + {{(QW-1){1'b0}}, adj};
    fits = (&q[QW-1:IMM_W-1]) | ~(|q[QW-1:IMM_W-1]);

    enc        = word & KEEP_MASK;
    enc[30:29] = q[1:0];
    enc[23:5]  = q[IMM_W-1:2];

    flags.patched = match & fits;
    flags.skipped = match & ~fits;
    word_out      = (match & fits) ? enc : word;
  end

endmodule

// ===== design/aptr_checker.sv =====
module aptr_checker import aptr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_word,
  input logic        was_patched,
  input logic        was_skipped
);

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word)
      && $stable(was_patched) && $stable(was_skipped))
    else $error("output item changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(was_patched && was_skipped))
    else $error("item both patched and skipped");

  // opcode bits survive a rewrite, so a non-ADRP result carries no flag
  a_non_adrp: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_word & ADRP_MASK) != ADRP_OP) |-> !was_patched && !was_skipped)
    else $error("flag raised on a non-ADRP word");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no output backpressure");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind adrp_page_target_rewriter aptr_checker u_aptr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_word    (out_word),
  .was_patched (was_patched),
  .was_skipped (was_skipped)
);

// ===== sim/testbench.sv =====
import aptr_pkg::*;

localparam int OFFSET_BITS = 28;
localparam int ADDR_BITS   = 48;

// Top of the reachable address space and the signed reach of a 21-bit page immediate.
localparam logic [63:0] ADDR_LIMIT = (64'd1 << ADDR_BITS) - 64'd1;
localparam longint      IMM_REACH  = longint'(1) << (IMM_W - 1);

typedef struct {
  logic [31:0] word;
  logic        patched;
  logic        skipped;
} rewrite_t;

// Holds a private copy of the four address registers and the queue of rewrites
// still owed by the block, oldest first.
class rewrite_scoreboard;
  logic [REG_W-1:0] code_base, phantom_start, phantom_end, data_base;
  rewrite_t rewritten_q[$];
  int errors, words_in, words_out, patched_cnt, skipped_cnt;

  function new();
    code_base     = '0;
    phantom_start = '0;
    phantom_end   = '0;
    data_base     = '0;
    errors        = 0;
    words_in      = 0;
    words_out     = 0;
    patched_cnt   = 0;
    skipped_cnt   = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
    case (idx)
      REG_CODE_BASE:     code_base = value;
      REG_PHANTOM_START: phantom_start = value;
      REG_PHANTOM_END:   phantom_end = value;
      REG_DATA_BASE:     data_base = value;
      default: ;
    endcase
  endfunction

  // Work out what the block must emit for one instruction word.
  function rewrite_t rewrite_adrp(logic [31:0] word, logic [OFFSET_BITS-1:0] offs);
    rewrite_t r;
    logic [63:0] pc, page, tgt, fresh, down;
    logic signed [IMM_W-1:0] imm21;
    longint imm, page_delta;
    r.word    = word;
    r.patched = 1'b0;
    r.skipped = 1'b0;
    if ((word & ADRP_MASK) != ADRP_OP) return r;

    pc    = 64'(code_base) + (64'(offs) << 2);
    page  = pc & ~64'hfff;
    imm21 = {word[23:5], word[30:29]};
    imm   = longint'(imm21);

    // Targets below zero or past the address space never match.
    if (imm < 0) begin
      down = 64'(-imm) << PAGE_SHIFT;
      if (down > page) return r;
      tgt = page - down;
    end else begin
      tgt = page + (64'(imm) << PAGE_SHIFT);
      if (tgt > ADDR_LIMIT) return r;
    end
    if (tgt < 64'(phantom_start) || tgt >= 64'(phantom_end)) return r;

    // Page distance truncates toward zero on both sides.
    fresh = 64'(data_base) + (tgt - 64'(phantom_start));
    if (fresh >= page) page_delta = longint'((fresh - page) >> PAGE_SHIFT);
    else page_delta = -longint'((page - fresh) >> PAGE_SHIFT);

    if (page_delta < -IMM_REACH || page_delta >= IMM_REACH) begin
      r.skipped = 1'b1;
      return r;
    end
    r.word         = word & KEEP_MASK;
    r.word[30:29]  = page_delta[1:0];
    r.word[23:5]   = page_delta[20:2];
    r.patched      = 1'b1;
    return r;
  endfunction

  function void take_word(logic [31:0] word, logic [OFFSET_BITS-1:0] offs);
    rewrite_t r;
    r = rewrite_adrp(word, offs);
    rewritten_q.insert(rewritten_q.size(), r);
    words_in++;
    if (r.patched) patched_cnt++;
    if (r.skipped) skipped_cnt++;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function void check_rewrite(logic [31:0] word, logic patched, logic skipped);
    rewrite_t want;
    if (rewritten_q.size() == 0) begin
      flag($sformatf("unexpected item: word %h patched %b skipped %b", word, patched, skipped));
      return;
    end
    want = rewritten_q.pop_front();
    words_out++;
    if (want.word !== word || want.patched !== patched || want.skipped !== skipped)
      flag($sformatf("expected word %h patched %b skipped %b, got word %h patched %b skipped %b",
                     want.word, want.patched, want.skipped, word, patched, skipped));
  endfunction

  function int pending();
    return rewritten_q.size();
  endfunction
endclass

module testbench;
  localparam int HALF_PERIOD  = 1;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 12;   // pipeline is five stages deep
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 230;
  localparam int NUM_PHASES   = 8;

  localparam logic [31:0]            ADR_OP    = 32'h1000_0000;  // ADR, the non-page form
  localparam logic [OFFSET_BITS-1:0] OFF_MAX   = '1;
  localparam logic [REG_W-1:0]       REG_MAX   = '1;
  localparam logic [REG_W-1:0]       PAGE_MASK = ~48'hfff;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [31:0]            instr_word = '0;
  logic [OFFSET_BITS-1:0] word_offset = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [31:0]            out_word;
  logic                   was_patched;
  logic                   was_skipped;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [REG_W-1:0]       cfg_data = '0;

  // Percent of cycles the sender idles and the receiver stalls, and a long
  // receiver hold-off counted down by the receiver process itself.
  int send_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int settings_cnt = 0;

  rewrite_scoreboard sb = new();

  adrp_page_target_rewriter #(
    .OFFSET_BITS(OFFSET_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .instr_word (instr_word),
    .word_offset(word_offset),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .was_patched(was_patched),
    .was_skipped(was_skipped),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Receiver: hold off for the requested stretch, otherwise stall at random.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
    end
  end

  // Monitors: sample pre-edge values, so an item counts exactly at the edge
  // where the block takes it.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.take_word(instr_word, word_offset);
    if (!rst && out_valid && !out_stall) sb.check_rewrite(out_word, was_patched, was_skipped);
  end

  function automatic logic [31:0] encode_adrp(logic [4:0] rd, longint imm);
    logic [31:0] w;
    logic [63:0] u;
    u        = imm;
    w        = ADRP_OP;
    w[30:29] = u[1:0];
    w[23:5]  = u[20:2];
    w[4:0]   = rd;
    return w;
  endfunction

  // Build an ADRP at the given word offset that reaches the page holding tgt
  // (immediate wraps to 21 bits when the page is out of reach).
  function automatic logic [31:0] adrp_toward(logic [63:0] tgt, logic [OFFSET_BITS-1:0] off,
                                              logic [4:0] rd);
    logic [63:0] page;
    page = (64'(sb.code_base) + (64'(off) << 2)) & ~64'hfff;
    return encode_adrp(rd, (longint'(tgt & ~64'hfff) - longint'(page)) >>> PAGE_SHIFT);
  endfunction

  // Offer one item, idling first at the current rate; return once it is taken.
  task automatic send_word(logic [31:0] w, logic [OFFSET_BITS-1:0] off);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    instr_word  <= w;
    word_offset <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every owed rewrite has come out; step one edge
  // first so the last accepted item is already on the books.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Hold valid across back-to-back writes; the caller drops it.
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic write_regs(logic [REG_W-1:0] cb, ps, pe, db);
    settle();
    put_reg(REG_CODE_BASE, cb);
    put_reg(REG_PHANTOM_START, ps);
    put_reg(REG_PHANTOM_END, pe);
    put_reg(REG_DATA_BASE, db);
    // An index past the register list must leave everything as it was.
    put_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_DATA_BASE + 1)),
            REG_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
    settings_cnt++;
  endtask

  // Keep the window near the code so that most ADRPs can reach it, and the
  // data region either near (rewrites fit) or anywhere (mostly out of reach).
  task automatic random_config();
    logic [REG_W-1:0] cb, ps, pe, db;
    cb = REG_W'({$urandom, $urandom});
    if ($urandom_range(3) == 0) cb = REG_W'($urandom);
    ps = cb + REG_W'($urandom_range(0, 2**29));
    if ($urandom_range(1) == 1) ps = ps & PAGE_MASK;
    pe = ps + REG_W'($urandom_range(1, 2**24));
    if ($urandom_range(9) == 0) pe = ps - REG_W'($urandom_range(0, 4096));
    if ($urandom_range(4) < 3) db = cb + REG_W'(longint'($urandom) - 64'sh8000_0000);
    else db = REG_W'({$urandom, $urandom});
    if ($urandom_range(9) != 0) db = db & PAGE_MASK;
    write_regs(cb, ps, pe, db);
  endtask

  // Mostly ADRPs aimed into or at the edges of the window from a nearby word,
  // the rest random ADRPs and arbitrary words.
  task automatic run_random(int count);
    logic [63:0] tgt, span;
    logic [OFFSET_BITS-1:0] off;
    logic [31:0] w;
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      off  = OFFSET_BITS'($urandom);
      if (pick < 70) begin
        span = (sb.phantom_end > sb.phantom_start) ?
               64'(sb.phantom_end - sb.phantom_start) : 64'h10_0000;
        case ($urandom_range(9))
          0:       tgt = 64'(sb.phantom_start);
          1:       tgt = 64'(sb.phantom_end) - 64'd1;
          2:       tgt = 64'(sb.phantom_end);
          default: tgt = 64'(sb.phantom_start) + ({$urandom, $urandom} % span);
        endcase
        if (tgt >= 64'(sb.code_base))
          off = OFFSET_BITS'(longint'((tgt - 64'(sb.code_base)) >> 2)
                             + longint'($urandom_range(0, 2**21)) - 64'sh10_0000);
        w = adrp_toward(tgt, off, 5'($urandom));
      end else if (pick < 85) begin
        w = encode_adrp(5'($urandom), longint'($urandom));
      end else begin
        w = $urandom;
      end
      send_word(w, off);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Window well inside reach of the code: plain words, window edges,
    // immediate extremes, and a negative target.
    write_regs(48'h0000_4000_0000, 48'h0000_8000_0000, 48'h0000_8010_0000, 48'h0000_4800_0000);
    send_word(32'h0000_0000, '0);
    send_word(32'hFFFF_FFFF, OFF_MAX);
    send_word(ADR_OP | 32'd7, 28'd1);
    send_word(adrp_toward(64'(sb.phantom_start), 28'd0, 5'd0), 28'd0);
    send_word(adrp_toward(64'(sb.phantom_end) - 64'd1, 28'd123, 5'd31), 28'd123);
    send_word(adrp_toward(64'(sb.phantom_end), 28'd7, 5'd5), 28'd7);
    send_word(adrp_toward(64'(sb.phantom_start) - 64'd1, 28'd9, 5'd3), 28'd9);
    send_word(adrp_toward(64'(sb.phantom_start) + 64'h5000, OFF_MAX, 5'd17), OFF_MAX);
    send_word(encode_adrp(5'd0, IMM_REACH - 64'sd1), 28'd2);
    send_word(encode_adrp(5'd12, -IMM_REACH), 28'd0);
    send_word(encode_adrp(5'd31, -64'sd1), 28'h400);

    // Code at the top of the address space, data region far below: matches
    // are out of reach, one step up leaves the space.
    write_regs(48'hFFFF_FFFF_F000, 48'h8000_0000_0000, REG_MAX, '0);
    send_word(encode_adrp(5'd1, 64'sd0), 28'd0);
    send_word(encode_adrp(5'd2, 64'sd1), 28'd0);
    send_word(encode_adrp(5'd3, -64'sh4_0000), OFF_MAX);
    send_word(encode_adrp(5'd4, -IMM_REACH), 28'd0);

    // Unaligned bases: distance truncates toward zero in both directions;
    // a page below the unaligned window start misses.
    write_regs(48'h1234, 48'h2345, 48'h0100_0000, 48'h0FFF);
    send_word(adrp_toward(64'h3000, 28'd0, 5'd2), 28'd0);
    send_word(adrp_toward(64'h3000, 28'h10_0000, 5'd9), 28'h10_0000);
    send_word(adrp_toward(64'h2000, 28'd0, 5'd4), 28'd0);

    // Empty, then inverted window: nothing matches.
    write_regs(48'h1234, 48'h2345, 48'h2345, 48'h0FFF);
    send_word(adrp_toward(64'h3000, 28'd0, 5'd2), 28'd0);
    write_regs(48'h1234, 48'h0100_0000, 48'h2345, 48'h0FFF);
    send_word(adrp_toward(64'h3000, 28'd0, 5'd2), 28'd0);

    // Random phases, cycling through the idling modes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1:       write_regs('0, '0, REG_MAX, '0);
        2:       write_regs(REG_MAX, '0, REG_MAX, REG_MAX & PAGE_MASK);
        default: random_config();
      endcase
      send_pct  = (p % 4 == 1) ? 74 : (p % 4 == 3) ? 28 : 0;
      stall_pct = (p % 4 == 2) ? 74 : (p % 4 == 3) ? 28 : 0;
      // Hold the receiver off while the sender keeps offering, so the pipe
      // fills and back-pressure reaches the input.
      if (p == 0) begin
        @(negedge clk) hold_left = HOLD_CYCLES;
        @(posedge clk);
      end
      run_random(PHASE_ITEMS);
    end

    settle();
    $display("Covered %0d words over %0d register settings: %0d rewritten, %0d out of reach.",
             sb.words_in, settings_cnt, sb.patched_cnt, sb.skipped_cnt);
    $display("Checked %0d results with idle-free, sender-idle, receiver-stall and mixed traffic.",
             sb.words_out);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
